[design/frcd_pkg.sv]
// ----------------------------------------------------------------------------
// frcd_pkg: shared types and constants for the frc dither block
// item layouts, mask geometry and the per-channel cycle start table
// ----------------------------------------------------------------------------
package frcd_pkg;

	localparam int FRAME_CYCLE = 8;
	localparam int MASK_SIZE   = 32;
	localparam int MASK_DEPTH  = MASK_SIZE * MASK_SIZE;
	localparam int MASK_AW     = $clog2(MASK_DEPTH);
	localparam int PHASE_W     = $clog2(FRAME_CYCLE);
	localparam int IN_W        = 12;
	localparam int OUT_W       = 8;
	localparam int NUM_CHAN    = 3;

	typedef enum logic {
		FUNC_DITHER  = 1'b0,
		FUNC_MASK_WR = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [PHASE_W-1:0] row_phase;
		logic [PHASE_W-1:0] col_phase;
		logic [PHASE_W-1:0] frame_phase;
		logic [IN_W-1:0]    red_in;
		logic [IN_W-1:0]    green_in;
		logic [IN_W-1:0]    blue_in;
		logic [MASK_AW-1:0] mask_addr;
		logic               mask_bit;
	} src_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] red_out;
		logic [OUT_W-1:0] green_out;
		logic [OUT_W-1:0] blue_out;
	} dst_item_t;

	// write port shared by the three mask copies
	typedef struct packed {
		logic               en;
		logic [MASK_AW-1:0] addr;
		logic               data;
	} mask_wr_t;

	// cycle start per channel, indexed by (row_phase >= 4, col_phase >= 4)
	localparam logic [1:0] CYCLE_START [NUM_CHAN][2][2] = '{
		'{'{2'd0, 2'd1}, '{2'd3, 2'd2}},
		'{'{2'd1, 2'd3}, '{2'd0, 2'd2}},
		'{'{2'd2, 2'd0}, '{2'd3, 2'd1}}
	};

	// column group: cycle start plus frame phase, wrapping at the frame cycle
	function automatic logic [PHASE_W-1:0] grp_col(
		input logic [1:0]         chan,
		input logic [PHASE_W-1:0] row_phase,
		input logic [PHASE_W-1:0] col_phase,
		input logic [PHASE_W-1:0] frame_phase
	);
		logic [1:0] start;
		start = CYCLE_START[chan][row_phase[PHASE_W-1]][col_phase[PHASE_W-1]];
		return PHASE_W'({{(PHASE_W-2){1'b0}}, start} + frame_phase);
	endfunction

endpackage

[design/frcd_chan.sv]
// ----------------------------------------------------------------------------
// frcd_chan: one color channel of the frc dither
// private copy of the dither mask, mask lookup and saturating round-up
// ----------------------------------------------------------------------------
module frcd_chan (
	input  logic                                clk,
	input  frcd_pkg::mask_wr_t                  mask_wr,
	input  logic                                rd_en,
	input  logic [frcd_pkg::IN_W-1:0]           value,
	input  logic [frcd_pkg::PHASE_W-1:0]        row_phase,
	input  logic [frcd_pkg::PHASE_W-1:0]        col_phase,
	input  logic [frcd_pkg::PHASE_W-1:0]        grp_col,
	output logic [frcd_pkg::OUT_W-1:0]          chan_out
);

	logic                          mask_q [frcd_pkg::MASK_DEPTH];
	logic [3:0]                    nib;
	logic [2:0]                    group;
	logic [frcd_pkg::MASK_AW-1:0]  rd_addr;
	logic                          bit_s1;
	logic                          inv_s1;
	logic                          zero_s1;
	logic [frcd_pkg::OUT_W-1:0]    hi_s1;
	logic                          up;

	assign nib = value[3:0];

	// nibble 1..7 picks group n-1, nibble 8..15 picks group 15-n
	assign group   = nib[3] ? ~nib[2:0] : (nib[2:0] - 3'd1);
	assign rd_addr = {group, row_phase[1:0], grp_col, col_phase[1:0]};

	always_ff @(posedge clk) begin
		if (mask_wr.en) begin
			mask_q[mask_wr.addr] <= mask_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			bit_s1  <= mask_q[rd_addr];
			inv_s1  <= nib[3];
			zero_s1 <= (nib == 4'd0);
			hi_s1   <= value[frcd_pkg::IN_W-1:frcd_pkg::IN_W-frcd_pkg::OUT_W];
		end
	end

	assign up       = !zero_s1 && (bit_s1 ^ inv_s1) && !(&hi_s1);
	assign chan_out = up ? (hi_s1 + frcd_pkg::OUT_W'(1)) : hi_s1;

endmodule

[design/frc_dither_12to8.sv]
// ----------------------------------------------------------------------------
// frc_dither_12to8: spatio-temporal frc dither, 12-bit to 8-bit rgb
// four-bit, eight-frame dither driven by a loadable 32x32 one-bit mask
// ----------------------------------------------------------------------------
// One item enters per clock while src_stall is low; a dither item's result
// leaves through two registers: the first is the synchronous read of the
// mask, the second is the result register. Each channel keeps its own copy
// of the 1024-bit mask so the three lookups of one pixel happen in the same
// read cycle; a mask-write item updates all three copies at once and gives
// no result. The mask has no reset and no clearing pass: every entry that
// dither items will touch must be written first. The input side keeps taking
// items while a finished result waits on a stalled output, as long as the
// read stage is empty. Channels whose low nibble is zero pass through
// truncated; a round-up at 255 saturates.
module frc_dither_12to8 (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  frcd_pkg::src_item_t  src_item,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output frcd_pkg::dst_item_t  dst_item
);

	logic                         adv;        // result register can load
	logic                         en_s1;      // read stage can load
	logic                         acc;        // item accepted this edge
	logic                         acc_dither;
	logic                         valid_s1;
	frcd_pkg::mask_wr_t           mask_wr;
	logic [frcd_pkg::OUT_W-1:0]   chan_out [frcd_pkg::NUM_CHAN];
	logic [frcd_pkg::IN_W-1:0]    chan_in  [frcd_pkg::NUM_CHAN];

	// handshake and stage enables
	assign adv        = !dst_valid || !dst_stall;
	assign en_s1      = !valid_s1 || adv;
	assign src_stall  = !en_s1;
	assign acc        = src_valid && en_s1;
	assign acc_dither = acc && (src_item.func == frcd_pkg::FUNC_DITHER);

	// mask writes go to every channel copy
	assign mask_wr.en   = acc && (src_item.func == frcd_pkg::FUNC_MASK_WR);
	assign mask_wr.addr = src_item.mask_addr;
	assign mask_wr.data = src_item.mask_bit;

	assign chan_in[0] = src_item.red_in;
	assign chan_in[1] = src_item.green_in;
	assign chan_in[2] = src_item.blue_in;

	for (genvar c = 0; c < frcd_pkg::NUM_CHAN; c++) begin : g_chan
		frcd_chan u_chan (
			.clk       (clk),
			.mask_wr   (mask_wr),
			.rd_en     (acc_dither),
			.value     (chan_in[c]),
			.row_phase (src_item.row_phase),
			.col_phase (src_item.col_phase),
			.grp_col   (frcd_pkg::grp_col(2'(c), src_item.row_phase,
			                              src_item.col_phase, src_item.frame_phase)),
			.chan_out  (chan_out[c])
		);
	end

	// read stage valid: only dither items carry on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= acc_dither;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (adv) begin
			dst_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			dst_item.red_out   <= chan_out[0];
			dst_item.green_out <= chan_out[1];
			dst_item.blue_out  <= chan_out[2];
		end
	end

`ifndef ASSERT_OFF
	// a mask write never turns into a result
	a_wr_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		mask_wr.en |=> !valid_s1)
		else $error("mask write item entered the read stage");

	// an accepted dither item always reaches the read stage
	a_dither_enters: assert property (@(posedge clk) disable iff (!arst_n)
		acc_dither |=> valid_s1)
		else $error("dither item lost at the read stage");

	// a pending item is held while the output is stalled
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && dst_valid && dst_stall) |=> valid_s1)
		else $error("read stage item dropped under output stall");
`endif

endmodule
